// ===== src/sliding_window_anagram_finder_assert.svh =====
// Assertion macros shared by the anagram finder RTL.
`ifndef SLIDING_WINDOW_ANAGRAM_FINDER_ASSERT_SVH
`define SLIDING_WINDOW_ANAGRAM_FINDER_ASSERT_SVH
`ifndef SYNTHESIS
// A condition that must hold on every clock edge out of reset.
`define SWAF_ASSERT_HOLD(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// An implication that is checked in the same cycle.
`define SWAF_ASSERT_IMPLY(lbl, clk, rst_n, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);
`else
`define SWAF_ASSERT_HOLD(lbl, clk, rst_n, cond, msg)
`define SWAF_ASSERT_IMPLY(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

// ===== src/swaf_pkg.sv =====
// Shared types and constants for the sliding window anagram finder.
`timescale 1ns / 1ps
`default_nettype none
package swaf_pkg;

  localparam int MAX_PATTERN_DEF = 64;
  localparam int ALPHABET_DEF    = 26;

  localparam int ACTION_W     = 2;
  localparam int LETTER_W     = 5;
  localparam int LETTER_CODES = 1 << LETTER_W;
  localparam int POS_W        = 32;

  // Action codes; the fourth code is ignored
  localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_APPEND = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_TEXT   = 2'd2;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [LETTER_W-1:0] letter;
  } in_item_t;

  typedef struct packed {
    logic             match;
    logic [POS_W-1:0] start_index;
    logic             pattern_overflow;
  } out_item_t;

  // Histogram update controls for one item
  typedef struct packed {
    logic clear;      // zero both histograms
    logic restart;    // zero the window histogram
    logic pat_add;    // count add_idx into the pattern
    logic text_add;   // count add_idx into the window
    logic text_drop;  // remove drop_idx from the window
  } hist_ctl_t;

endpackage
`default_nettype wire

// ===== src/sliding_window_anagram_finder.sv =====
// Sliding window anagram finder top level.
// Input channel (in_valid/in_stall/in_data) carries one action per transfer:
// clear, append a pattern letter, or stream a text letter. Each text letter
// gives exactly one result transfer on the output channel
// (out_valid/out_stall/out_data): a match flag, the window start index
// (zero unless matched) and the sticky pattern overflow flag. Clear and
// append transfers give no result.
// A result passes through the input register, then the result register.
// Throughput: one item per cycle while no stalled result holds back a text
// letter, set by the histogram lane update and the ring read that is fetched
// ahead from the next write pointer.
// Reset (rst_n low, synchronous) empties the pattern, the window and the
// overflow flag at once; no clearing pass, items are taken on the next cycle.
// While out_stall holds a result, the block keeps taking clear and append
// transfers and one more text letter, which then waits in the input
// register and raises in_stall until the result register frees up.
`timescale 1ns / 1ps
`default_nettype none
`include "sliding_window_anagram_finder_assert.svh"
module sliding_window_anagram_finder #(
  parameter int MAX_PATTERN = swaf_pkg::MAX_PATTERN_DEF,
  parameter int ALPHABET    = swaf_pkg::ALPHABET_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire swaf_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output swaf_pkg::out_item_t      out_data
);
  import swaf_pkg::*;

  localparam int PTR_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int CNT_W = $clog2(MAX_PATTERN + 1);
  localparam int IDX_W = $clog2(ALPHABET);

  // input register
  logic       in_vld_r;
  in_item_t   in_r;
  // result register
  logic       out_vld_r;
  out_item_t  out_r;
  // window state
  logic [CNT_W-1:0] plen_r, plen_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [PTR_W-1:0] wr_r, wr_nxt;
  logic [POS_W-1:0] tpos_r, tpos_nxt;
  logic             ovf_r, ovf_nxt;
  // ring read path
  logic             byp_r;
  logic [IDX_W-1:0] byp_data_r;
  logic [IDX_W-1:0] ram_q;
  logic [CNT_W:0]   rd_sum, rd_wrap;
  logic [PTR_W-1:0] rd_addr;
  logic             ram_we;
  // item decode
  logic [IDX_W-1:0] lmap [LETTER_CODES];
  logic [IDX_W-1:0] idx, oldest;
  logic             act_text, out_free, fire;
  logic             do_clear, do_append, do_text, text_live;
  logic             pat_room, win_full;
  logic             all_eq_nxt, match_nxt;
  logic [POS_W-1:0] start_nxt;
  hist_ctl_t        hctl;

  // letter code reduced modulo the alphabet size
  for (genvar g = 0; g < LETTER_CODES; g++) begin : g_lmap
    assign lmap[g] = IDX_W'(g % ALPHABET);
  end

  // flow control: a text letter waits only on a full, stalled result register
  assign idx      = lmap[in_r.letter];
  assign act_text = (in_r.action == ACT_TEXT);
  assign out_free = !out_vld_r || !out_stall;
  assign fire     = in_vld_r && (!act_text || out_free);
  assign in_stall = in_vld_r && !fire;

  assign do_clear  = fire && (in_r.action == ACT_CLEAR);
  assign do_append = fire && (in_r.action == ACT_APPEND);
  assign do_text   = fire && act_text;
  assign text_live = do_text && (plen_r != '0);
  assign pat_room  = (plen_r != CNT_W'(MAX_PATTERN));
  assign win_full  = (fill_r == plen_r);
  assign oldest    = byp_r ? byp_data_r : ram_q;

  // next window state
  always_comb begin
    plen_nxt = plen_r;
    fill_nxt = fill_r;
    wr_nxt   = wr_r;
    tpos_nxt = tpos_r;
    ovf_nxt  = ovf_r;
    if (do_clear) begin
      plen_nxt = '0;
      fill_nxt = '0;
      wr_nxt   = '0;
      tpos_nxt = '0;
      ovf_nxt  = 1'b0;
    end else if (do_append) begin
      if (pat_room) begin
        plen_nxt = plen_r + CNT_W'(1);
      end else begin
        ovf_nxt = 1'b1;
      end
      fill_nxt = '0;
      wr_nxt   = '0;
      tpos_nxt = '0;
    end else if (do_text) begin
      tpos_nxt = tpos_r + POS_W'(1);
      if (plen_r != '0) begin
        if (!win_full) begin
          fill_nxt = fill_r + CNT_W'(1);
        end
        wr_nxt = (wr_r == PTR_W'(MAX_PATTERN - 1)) ? '0 : wr_r + PTR_W'(1);
      end
    end
  end

  // result of the current text letter
  assign match_nxt = text_live && (fill_nxt == plen_r) && all_eq_nxt;
  assign start_nxt = match_nxt ? (tpos_r + POS_W'(1) - POS_W'(plen_r)) : '0;

  // histogram lanes
  assign hctl.clear     = do_clear;
  assign hctl.restart   = do_append;
  assign hctl.pat_add   = do_append && pat_room;
  assign hctl.text_add  = text_live;
  assign hctl.text_drop = text_live && win_full;

  swaf_hist #(
    .ALPHABET (ALPHABET),
    .CNT_W    (CNT_W),
    .IDX_W    (IDX_W)
  ) u_hist (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (hctl),
    .add_idx    (idx),
    .drop_idx   (oldest),
    .all_eq_nxt (all_eq_nxt)
  );

  // ring of window letters; oldest entry fetched from the next pointer state
  assign ram_we  = text_live;
  assign rd_sum  = (CNT_W+1)'(wr_nxt) + (CNT_W+1)'(MAX_PATTERN) - (CNT_W+1)'(plen_nxt);
  assign rd_wrap = (rd_sum >= (CNT_W+1)'(MAX_PATTERN)) ? rd_sum - (CNT_W+1)'(MAX_PATTERN)
                                                       : rd_sum;
  assign rd_addr = rd_wrap[PTR_W-1:0];

  swaf_ram #(
    .WIDTH (IDX_W),
    .DEPTH (MAX_PATTERN),
    .AW    (PTR_W)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_r),
    .wdata (idx),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      plen_r    <= '0;
      fill_r    <= '0;
      wr_r      <= '0;
      tpos_r    <= '0;
      ovf_r     <= 1'b0;
      byp_r     <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_vld_r <= in_valid;
      end
      if (do_text) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
      plen_r <= plen_nxt;
      fill_r <= fill_nxt;
      wr_r   <= wr_nxt;
      tpos_r <= tpos_nxt;
      ovf_r  <= ovf_nxt;
      // same-address write and read: forward the new letter
      byp_r  <= ram_we && (wr_r == rd_addr);
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_r <= in_data;
    end
    if (do_text) begin
      out_r.match            <= match_nxt;
      out_r.start_index      <= start_nxt;
      out_r.pattern_overflow <= ovf_r;
    end
    byp_data_r <= idx;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  // window fill never runs past the pattern length
  `SWAF_ASSERT_HOLD(a_fill_bound, clk, rst_n, fill_r <= plen_r, "window fill exceeds pattern")
  // until the window fills, the ring pointer tracks the fill count
  `SWAF_ASSERT_IMPLY(a_ptr_fill, clk, rst_n, fill_r != plen_r, CNT_W'(wr_r) == fill_r, "ring pointer out of step")
  // overflow is only possible with a full pattern
  `SWAF_ASSERT_IMPLY(a_ovf_full, clk, rst_n, ovf_r, plen_r == CNT_W'(MAX_PATTERN), "overflow without full pattern")

endmodule
`default_nettype wire

// ===== src/swaf_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module swaf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read-first: a same-address write shows up on the next read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== src/swaf_hist.sv =====
// Pattern and window letter histograms, one lane per letter, with match compare.
`timescale 1ns / 1ps
`default_nettype none
module swaf_hist #(
  parameter int ALPHABET = 26,
  parameter int CNT_W    = 7,
  parameter int IDX_W    = 5
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire swaf_pkg::hist_ctl_t ctl,
  input  wire logic [IDX_W-1:0]    add_idx,
  input  wire logic [IDX_W-1:0]    drop_idx,
  output logic                     all_eq_nxt
);
  import swaf_pkg::*;

  logic [CNT_W-1:0]    pc_r   [ALPHABET];
  logic [CNT_W-1:0]    pc_nxt [ALPHABET];
  logic [CNT_W-1:0]    wc_r   [ALPHABET];
  logic [CNT_W-1:0]    wc_nxt [ALPHABET];
  logic [ALPHABET-1:0] eq_nxt;

  for (genvar k = 0; k < ALPHABET; k++) begin : g_lane
    logic hit_add;
    logic hit_drop;

    assign hit_add  = (add_idx == IDX_W'(k));
    // an empty count stays at zero on a drop
    assign hit_drop = ctl.text_drop && (drop_idx == IDX_W'(k)) && (wc_r[k] != '0);

    // lane update
    always_comb begin
      pc_nxt[k] = pc_r[k];
      wc_nxt[k] = wc_r[k];
      if (ctl.clear) begin
        pc_nxt[k] = '0;
        wc_nxt[k] = '0;
      end else if (ctl.restart) begin
        wc_nxt[k] = '0;
        if (ctl.pat_add && hit_add) begin
          pc_nxt[k] = pc_r[k] + CNT_W'(1);
        end
      end else if (ctl.text_add) begin
        wc_nxt[k] = wc_r[k] + CNT_W'(hit_add) - CNT_W'(hit_drop);
      end
    end

    assign eq_nxt[k] = (wc_nxt[k] == pc_nxt[k]);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        pc_r[k] <= '0;
        wc_r[k] <= '0;
      end else begin
        pc_r[k] <= pc_nxt[k];
        wc_r[k] <= wc_nxt[k];
      end
    end
  end

  // window is an anagram when every lane agrees
  assign all_eq_nxt = &eq_nxt;

endmodule
`default_nettype wire

// ===== sim/anagram_match_checker.sv =====
// Predicts the anagram finder's results from the input transfers and compares them.
`timescale 1ns / 1ps
module anagram_match_checker (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic                in_stall,
  input  wire swaf_pkg::in_item_t  in_data,
  input  wire logic                out_valid,
  input  wire logic                out_stall,
  input  wire swaf_pkg::out_item_t out_data,
  output int                       fails,
  output int                       pending
);
  import swaf_pkg::*;

  localparam int PAT_CAP     = MAX_PATTERN_DEF;
  localparam int NUM_LETTERS = ALPHABET_DEF;

  // Mirror of the block's state
  logic [6:0]          pat_hist [NUM_LETTERS];
  logic [6:0]          win_hist [NUM_LETTERS];
  logic [LETTER_W-1:0] ring     [PAT_CAP];
  int unsigned         pat_len;
  int unsigned         win_fill;
  int unsigned         ring_wr;
  int                  diff_letters;
  logic [POS_W-1:0]    text_pos;
  logic                overflow;

  out_item_t expected_matches[$];
  out_item_t want;
  int        errs;

  initial begin
    fails   = 0;
    pending = 0;
    errs    = 0;
  end

  task automatic forget_all();
    for (int k = 0; k < NUM_LETTERS; k++) begin
      pat_hist[k] = '0;
      win_hist[k] = '0;
    end
    for (int k = 0; k < PAT_CAP; k++) ring[k] = '0;
    pat_len      = 0;
    win_fill     = 0;
    ring_wr      = 0;
    diff_letters = 0;
    text_pos     = '0;
    overflow     = 1'b0;
  endtask

  // Empty the window; every letter present in the pattern starts out unbalanced
  task automatic rewind_window();
    win_fill     = 0;
    ring_wr      = 0;
    text_pos     = '0;
    diff_letters = 0;
    for (int k = 0; k < NUM_LETTERS; k++) begin
      win_hist[k] = '0;
      if (pat_hist[k] != 0) diff_letters++;
    end
  endtask

  // Move one window count and keep the unbalanced-letter count in step
  task automatic tally_window(int unsigned idx, bit up);
    int was_off;
    was_off = int'(win_hist[idx] != pat_hist[idx]);
    if (up) win_hist[idx] = win_hist[idx] + 7'd1;
    else if (win_hist[idx] != 0) win_hist[idx] = win_hist[idx] - 7'd1;
    diff_letters = diff_letters + int'(win_hist[idx] != pat_hist[idx]) - was_off;
  endtask

  task automatic predict_item(in_item_t it);
    int unsigned idx;
    out_item_t   res;
    idx = int'(it.letter) % NUM_LETTERS;
    res = '0;
    case (it.action)
      ACT_CLEAR: forget_all();
      ACT_APPEND: begin
        // a full pattern drops the letter but still restarts the window
        if (pat_len < PAT_CAP) begin
          pat_hist[idx] = pat_hist[idx] + 7'd1;
          pat_len++;
        end else begin
          overflow = 1'b1;
        end
        rewind_window();
      end
      ACT_TEXT: begin
        if (pat_len != 0) begin
          if (win_fill >= pat_len) begin
            tally_window(int'(ring[(ring_wr + PAT_CAP - pat_len) % PAT_CAP]) % NUM_LETTERS, 1'b0);
          end else begin
            win_fill++;
          end
          ring[ring_wr] = idx[LETTER_W-1:0];
          ring_wr = (ring_wr + 1) % PAT_CAP;
          tally_window(idx, 1'b1);
          if (win_fill >= pat_len && diff_letters == 0) begin
            res.match       = 1'b1;
            res.start_index = text_pos + 32'd1 - pat_len;
          end
        end
        text_pos = text_pos + 32'd1;
        res.pattern_overflow = overflow;
        expected_matches = {expected_matches, res};
      end
      default: ;  // unused code, ignored
    endcase
  endtask

  task automatic check_result(out_item_t got);
    if (expected_matches.size() == 0) begin
      $error("result with no text letter pending: match=%0d start_index=%0d",
             got.match, got.start_index);
      errs++;
    end else begin
      want = expected_matches.pop_front();
      if (got.match !== want.match) begin
        $error("match: expected %0d, got %0d", want.match, got.match);
        errs++;
      end
      if (got.start_index !== want.start_index) begin
        $error("start_index: expected %0d, got %0d", want.start_index, got.start_index);
        errs++;
      end
      if (got.pattern_overflow !== want.pattern_overflow) begin
        $error("pattern_overflow: expected %0d, got %0d",
               want.pattern_overflow, got.pattern_overflow);
        errs++;
      end
    end
  endtask

  // Results are checked before the same edge's input transfer is applied
  always @(posedge clk) begin
    if (!rst_n) begin
      forget_all();
      expected_matches.delete();
    end else begin
      if (out_valid && !out_stall) check_result(out_data);
      if (in_valid && !in_stall) predict_item(in_data);
    end
    pending <= expected_matches.size();
    fails   <= errs;
  end

endmodule

// ===== sim/tb_sliding_window_anagram_finder.sv =====
// Testbench top for the anagram finder: clock, reset, stimulus, stalls and verdict.
`timescale 1ns / 1ps
module tb_sliding_window_anagram_finder;
  import swaf_pkg::*;

  localparam int ITEM_TARGET = 1100;
  localparam int CYCLE_LIMIT = 500000;
  localparam int LONG_HOLD   = 200;
  localparam logic [ACTION_W-1:0] ACT_NOP = 2'd3;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  int        fails;
  int        pending;

  bit          tx_idle    = 1'b0;
  bit          hold_req   = 1'b0;
  int unsigned items_sent = 0;
  int unsigned cycle_count;
  logic [LETTER_W-1:0] pat_letters[$];

  always #10 clk = ~clk;

  sliding_window_anagram_finder uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  anagram_match_checker u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .fails     (fails),
    .pending   (pending)
  );

  // One input transfer, after a random gap when the sender is in its idling mode
  task automatic send(logic [ACTION_W-1:0] act, logic [LETTER_W-1:0] letter);
    int unsigned gap;
    in_item_t    it;
    gap = tx_idle ? $urandom_range(0, 16) : 0;
    it.action = act;
    it.letter = letter;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    if (act != ACT_NOP) items_sent++;
  endtask

  // Letters below the pool size; now and then a code past the alphabet that folds back
  function automatic logic [LETTER_W-1:0] pick_letter(int unsigned pool);
    int unsigned v;
    v = $urandom_range(0, pool - 1);
    if (v < LETTER_CODES - ALPHABET_DEF && $urandom_range(0, 7) == 0) v += ALPHABET_DEF;
    return v[LETTER_W-1:0];
  endfunction

  task automatic add_pattern(int unsigned n, int unsigned pool);
    logic [LETTER_W-1:0] l;
    repeat (n) begin
      l = pick_letter(pool);
      send(ACT_APPEND, l);
      if (pat_letters.size() < MAX_PATTERN_DEF) pat_letters = {pat_letters, l};
    end
  endtask

  // Text mixes shuffled copies of the pattern with random letters and some noise
  task automatic stream_text(int unsigned n, int unsigned pool);
    logic [LETTER_W-1:0] perm[$];
    logic [LETTER_W-1:0] tmp;
    int unsigned         j;
    int unsigned         sent;
    sent = 0;
    while (sent < n) begin
      if (pat_letters.size() != 0 && $urandom_range(0, 2) == 0) begin
        perm = pat_letters;
        for (int k = perm.size() - 1; k > 0; k--) begin
          j       = $urandom_range(0, k);
          tmp     = perm[k];
          perm[k] = perm[j];
          perm[j] = tmp;
        end
        foreach (perm[i]) send(ACT_TEXT, perm[i]);
        sent += perm.size();
      end else begin
        send(ACT_TEXT, pick_letter(pool));
        sent++;
      end
      case ($urandom_range(0, 39))
        0, 1: send(ACT_NOP, LETTER_W'($urandom_range(0, 31)));
        2: add_pattern(1, pool);  // stray pattern letter breaks the search
        default: ;
      endcase
    end
  endtask

  // Hold the input until every predicted result has been seen
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Result side: random stalls, idle-free stretches and one long hold-off on request
  initial begin : result_sink
    int unsigned hold;
    bit          rx_idle;
    rx_idle = 1'b0;
    forever begin
      if ($urandom_range(0, 31) == 0) rx_idle = !rx_idle;
      hold = rx_idle ? $urandom_range(0, 16) : 0;
      if (hold_req) begin
        hold = LONG_HOLD;
        hold_req <= 1'b0;
      end
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin : watchdog
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk);
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    int unsigned plen;
    int unsigned tlen;
    int unsigned pool;
    int unsigned kind;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty pattern, ignored code, folded letters, matches, restart, clear
    send(ACT_TEXT, 5'd0);
    send(ACT_TEXT, 5'd31);
    send(ACT_NOP, 5'd31);
    send(ACT_APPEND, 5'd0);
    send(ACT_APPEND, 5'd27);
    send(ACT_TEXT, 5'd1);
    send(ACT_TEXT, 5'd26);
    send(ACT_TEXT, 5'd0);
    send(ACT_TEXT, 5'd1);
    send(ACT_TEXT, 5'd31);
    send(ACT_APPEND, 5'd25);
    send(ACT_TEXT, 5'd25);
    send(ACT_TEXT, 5'd0);
    send(ACT_TEXT, 5'd1);
    send(ACT_TEXT, 5'd30);
    send(ACT_CLEAR, 5'd0);
    send(ACT_TEXT, 5'd1);
    send(ACT_APPEND, 5'd31);
    send(ACT_TEXT, 5'd5);
    send(ACT_TEXT, 5'd31);
    send(ACT_TEXT, 5'd16);
    send(ACT_NOP, 5'd0);
    send(ACT_CLEAR, 5'd31);

    // receiver holds off while the sender keeps offering text
    drain_results();
    tx_idle  = 1'b0;
    hold_req <= 1'b1;
    add_pattern(2, 3);
    stream_text(40, 3);
    drain_results();

    // pattern past capacity, then text that fills the largest window
    send(ACT_CLEAR, 5'd0);
    pat_letters.delete();
    add_pattern(67, 26);
    stream_text(140, 26);

    // random search sequences
    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 3) == 0) tx_idle = !tx_idle;
      if ($urandom_range(0, 11) == 0) drain_results();
      if ($urandom_range(0, 3) != 0 || pat_letters.size() > 8) begin
        send(ACT_CLEAR, LETTER_W'($urandom_range(0, 31)));
        pat_letters.delete();
      end
      kind = $urandom_range(0, 15);
      pool = $urandom_range(2, 26);
      if (kind == 0) begin
        plen = $urandom_range(58, 70);
        tlen = $urandom_range(70, 140);
      end else begin
        plen = $urandom_range(0, 5);
        tlen = $urandom_range(4, 40);
      end
      add_pattern(plen, pool);
      stream_text(tlen, pool);
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (fails == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
